### rtl/sfrx_pkg.sv
// ============================================================================
// sfrx_pkg
// Shared types and constants for the serial frame receiver with XOR check.
// ============================================================================
`default_nettype none

package sfrx_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_BYTE_RST = 8'd0;
    localparam logic [7:0] END_BYTE_RST    = 8'd0;
    localparam logic [7:0] MAX_LEN_RST     = 8'd255;

    // One received item.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } sfrx_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       payload_valid;
        logic       frame_done;
        logic       frame_ok;
        logic [7:0] seq_number;
        logic [7:0] command;
        logic [7:0] payload_length;
        logic       rx_busy;
    } sfrx_out_t;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] end_byte;
        logic [7:0] max_payload_len;
    } sfrx_cfg_t;

endpackage

`default_nettype wire

### rtl/sfrx_cfg_regs.sv
// ============================================================================
// sfrx_cfg_regs
// Configuration register file for the frame receiver.
// ============================================================================
`default_nettype none

module sfrx_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [sfrx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                         cfg_data,
    output sfrx_pkg::sfrx_cfg_t                     cfg
);

    sfrx_pkg::sfrx_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte     <= sfrx_pkg::HEADER_BYTE_RST;
            cfg_reg.end_byte        <= sfrx_pkg::END_BYTE_RST;
            cfg_reg.max_payload_len <= sfrx_pkg::MAX_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfrx_pkg::CFG_HEADER_BYTE: cfg_reg.header_byte     <= cfg_data;
                sfrx_pkg::CFG_END_BYTE:    cfg_reg.end_byte        <= cfg_data;
                sfrx_pkg::CFG_MAX_LEN:     cfg_reg.max_payload_len <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/sfrx_parser.sv
// ============================================================================
// sfrx_parser
// Frame parser state and the combinational step that forms one result item.
// ============================================================================
`default_nettype none

module sfrx_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire sfrx_pkg::sfrx_in_t  item,
    input  wire sfrx_pkg::sfrx_cfg_t cfg,
    output sfrx_pkg::sfrx_out_t      result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SEQ     = 3'd1;
    localparam logic [2:0] PH_CMD     = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;
    localparam logic [2:0] PH_END     = 3'd6;

    logic [2:0] phase_reg,  phase_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] xor_reg,    xor_next;
    logic [7:0] seq_reg,    seq_next;
    logic [7:0] cmd_reg,    cmd_next;
    logic [7:0] check_reg,  check_next;
    logic       busy_reg,   busy_next;
    logic [7:0] count_inc;
    logic [7:0] b;

    assign b         = item.rx_byte;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        seq_next   = seq_reg;
        cmd_next   = cmd_reg;
        check_next = check_reg;
        busy_next  = busy_reg;

        result = '0;

        if (!item.line_error)
        begin
            busy_next = 1'b1;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == cfg.header_byte)
                    begin
                        xor_next   = 8'd0;
                        count_next = 8'd0;
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    seq_next   = b;
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = b;
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = b;
                    xor_next   = xor_reg ^ b;
                    count_next = 8'd0;
                    if (b == 8'd0)
                        phase_next = PH_CHECK;
                    else if (b <= cfg.max_payload_len)
                        phase_next = PH_PAYLOAD;
                    else
                        phase_next = PH_HUNT;
                end
                PH_PAYLOAD:
                begin
                    xor_next             = xor_reg ^ b;
                    result.payload_byte  = b;
                    result.payload_index = count_reg;
                    result.payload_valid = 1'b1;
                    if (count_inc >= len_reg)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_CHECK:
                begin
                    check_next = b;
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    if (b == cfg.end_byte)
                    begin
                        result.frame_done = 1'b1;
                        result.frame_ok   = (~xor_reg == check_reg);
                        busy_next         = 1'b0;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        result.seq_number     = seq_next;
        result.command        = cmd_next;
        result.payload_length = len_next;
        result.rx_busy        = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= 8'd0;
            len_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            seq_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            check_reg <= 8'd0;
            busy_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            seq_reg   <= seq_next;
            cmd_reg   <= cmd_next;
            check_reg <= check_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

### rtl/serial_frame_receiver_xor_check.sv
// ============================================================================
// serial_frame_receiver_xor_check
// Length-prefixed frame deframer with a running inverted-XOR check byte.
// ============================================================================
// Each input item is one received byte with a line-error flag, and each
// accepted item yields exactly one result item. The block sustains one item
// per clock cycle while the downstream side does not stall: the item is
// captured in an input register, the parser updates its state as the item
// moves into the result register, and the result waits there until the
// downstream side takes it. That parser update as the item moves on sets the
// rate. A frame is a header byte, sequence, command, length, the payload
// bytes, a check byte and an end byte; payload bytes come out one per result
// with their index, and the result that sees a matching end byte carries
// frame_done, with frame_ok set when the inverted XOR of sequence, command,
// length and payload equals the check byte. Bytes with line_error set are
// dropped without touching the parser state. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while the block is
// idle; writes to an index beyond the register list are ignored.
// ============================================================================
`default_nettype none

module serial_frame_receiver_xor_check (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Received byte channel.
    input  wire logic                               rx_valid,
    output logic                                    rx_stall,
    input  wire sfrx_pkg::sfrx_in_t                 rx_item,

    // Result channel.
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output sfrx_pkg::sfrx_out_t                     res_item,

    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sfrx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                         cfg_data
);

    sfrx_pkg::sfrx_cfg_t cfg;
    sfrx_pkg::sfrx_in_t  in_reg;
    sfrx_pkg::sfrx_out_t out_reg;
    sfrx_pkg::sfrx_out_t step_result;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                rx_take;

    assign cfg_ready = 1'b1;

    sfrx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held item moves on whenever the result register is empty or its
    // item is being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !res_stall);

    // The input register can take a new item when it is empty or its item
    // moves on in this same cycle.
    assign rx_stall = in_valid_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            in_reg <= rx_item;
    end

    // The parser state steps exactly once for each item that moves on.
    sfrx_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!res_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step_result;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for serial_frame_receiver_xor_check.
// ============================================================================
// The bench feeds received bytes through the valid/stall input channel. A
// behavioral copy of the frame parser predicts one result item for every
// byte the block accepts. A monitor compares each accepted result item, field
// by field, with the oldest prediction. Traffic starts with a short
// hand-built sequence. Several randomized phases follow, each with its own
// header, end and maximum-length setting. Line errors, corrupted check bytes,
// wrong end bytes, oversized lengths and noise bytes are mixed into
// well-formed frames. Both channels idle and stall at random, with burst
// stretches in between.
// ============================================================================

module testbench;

    // Parser phases, in the order in which a frame walks through them.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SEQ,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END
    } parse_ph_t;

    // Ways in which a generated frame can be shaped.
    typedef enum int {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_END,
        FR_TOO_LONG
    } frame_kind_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  rx_valid = 1'b0;
    logic                  rx_stall;
    sfrx_pkg::sfrx_in_t    rx_item = '0;

    logic                  res_valid;
    logic                  res_stall = 1'b0;
    sfrx_pkg::sfrx_out_t   res_item;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sfrx_pkg::CFG_IDX_W-1:0]  cfg_index = sfrx_pkg::CFG_HEADER_BYTE;
    logic [7:0]                      cfg_data = 8'h00;

    always #4 clk = ~clk;

    serial_frame_receiver_xor_check u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    sfrx_pkg::sfrx_in_t   byte_q[$];       // bytes waiting to be sent
    sfrx_pkg::sfrx_out_t  deframed_q[$];   // predicted result items, oldest first

    // Copy of the configuration, updated when a register write is taken.
    logic [7:0] hdr_cfg = sfrx_pkg::HEADER_BYTE_RST;
    logic [7:0] end_cfg = sfrx_pkg::END_BYTE_RST;
    logic [7:0] max_cfg = sfrx_pkg::MAX_LEN_RST;

    // Copy of the parser state.
    parse_ph_t  parse_ph = PH_HUNT;
    logic [7:0] pay_cnt = 8'h00;
    logic [7:0] decl_len = 8'h00;
    logic [7:0] xor_acc = 8'h00;
    logic [7:0] seq_q = 8'h00;
    logic [7:0] cmd_q = 8'h00;
    logic [7:0] chk_q = 8'h00;
    logic       busy = 1'b0;

    int  send_gap = 0;          // idle cycles before the next byte goes out
    int  sink_hold = 0;         // stall cycles left on the result side
    bit  sender_burst = 1'b0;   // when set, the sender never idles
    bit  sink_burst = 1'b0;     // when set, the result side never stalls
    int  line_err_pct = 0;      // chance of a line-error byte before each byte
    int  fed_bytes = 0;         // bytes without a line error queued so far
    int  n_mismatch = 0;
    int  n_results = 0;

    // ------------------------------------------------------------------------
    // Parser prediction. It advances the copied state by one byte and returns
    // the result item that byte must produce.
    // ------------------------------------------------------------------------
    function automatic sfrx_pkg::sfrx_out_t deframe_byte(sfrx_pkg::sfrx_in_t it);
        sfrx_pkg::sfrx_out_t  r;
        logic [7:0] b;
        r = '0;
        b = it.rx_byte;
        // A byte with a line error leaves the parser untouched.
        if (!it.line_error)
        begin
            busy = 1'b1;
            case (parse_ph)
                PH_HUNT:
                begin
                    if (b == hdr_cfg)
                    begin
                        xor_acc = 8'h00;
                        pay_cnt = 8'h00;
                        parse_ph = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    seq_q = b;
                    xor_acc ^= b;
                    parse_ph = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_q = b;
                    xor_acc ^= b;
                    parse_ph = PH_LEN;
                end
                PH_LEN:
                begin
                    decl_len = b;
                    xor_acc ^= b;
                    pay_cnt = 8'h00;
                    // Zero skips the payload; an oversized length aborts.
                    if (b == 8'h00)
                        parse_ph = PH_CHECK;
                    else if (b <= max_cfg)
                        parse_ph = PH_PAYLOAD;
                    else
                        parse_ph = PH_HUNT;
                end
                PH_PAYLOAD:
                begin
                    xor_acc ^= b;
                    r.payload_byte = b;
                    r.payload_index = pay_cnt;
                    r.payload_valid = 1'b1;
                    pay_cnt = pay_cnt + 8'd1;
                    if (pay_cnt >= decl_len)
                    begin
                        pay_cnt = 8'h00;
                        parse_ph = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    chk_q = b;
                    parse_ph = PH_END;
                end
                PH_END:
                begin
                    // A wrong end byte drops the frame without any mark.
                    if (b == end_cfg)
                    begin
                        r.frame_done = 1'b1;
                        r.frame_ok = (~xor_acc == chk_q);
                        busy = 1'b0;
                    end
                    parse_ph = PH_HUNT;
                end
                default:
                begin
                    parse_ph = PH_HUNT;
                end
            endcase
        end
        r.seq_number = seq_q;
        r.command = cmd_q;
        r.payload_length = decl_len;
        r.rx_busy = busy;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    task automatic field_check(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver. The pending byte queue feeds the input channel. Each byte that
    // is taken is run through the prediction at the same edge. The sender
    // then waits a random number of cycles before it offers the next byte.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && !rx_stall)
                deframed_q.push_back(deframe_byte(rx_item));
            // The channel is free when nothing is offered or the offer was taken.
            if (!rx_valid || !rx_stall)
            begin
                if (send_gap > 0)
                begin
                    rx_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (byte_q.size() != 0)
                begin
                    rx_item <= byte_q.pop_front();
                    rx_valid <= 1'b1;
                    send_gap <= sender_burst ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. It checks every result item the bench takes and then stalls
    // the result channel for a random number of cycles.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sfrx_pkg::sfrx_out_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (deframed_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              n_results));
                end
                else
                begin
                    want = deframed_q.pop_front();
                    field_check("payload_byte", int'(res_item.payload_byte),
                                int'(want.payload_byte));
                    field_check("payload_index", int'(res_item.payload_index),
                                int'(want.payload_index));
                    field_check("payload_valid", int'(res_item.payload_valid),
                                int'(want.payload_valid));
                    field_check("frame_done", int'(res_item.frame_done),
                                int'(want.frame_done));
                    field_check("frame_ok", int'(res_item.frame_ok),
                                int'(want.frame_ok));
                    field_check("seq_number", int'(res_item.seq_number),
                                int'(want.seq_number));
                    field_check("command", int'(res_item.command),
                                int'(want.command));
                    field_check("payload_length", int'(res_item.payload_length),
                                int'(want.payload_length));
                    field_check("rx_busy", int'(res_item.rx_busy),
                                int'(want.rx_busy));
                end
                n_results++;
                sink_hold = sink_burst ? 0 : $urandom_range(0, 7);
            end
            if (sink_hold > 0)
            begin
                res_stall <= 1'b1;
                sink_hold--;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_raw(logic [7:0] b, logic err);
        sfrx_pkg::sfrx_in_t it;
        it.rx_byte = b;
        it.line_error = err;
        byte_q.push_back(it);
        if (!err)
            fed_bytes++;
    endtask

    // Queues one byte. A random line-error byte may be slipped in ahead of it.
    task automatic add_byte(logic [7:0] b);
        if ($urandom_range(0, 99) < line_err_pct)
            add_raw(8'($urandom), 1'b1);
        add_raw(b, 1'b0);
    endtask

    // Builds a frame for the current header and end setting. The check byte
    // is computed like the block does it, as the inverted running XOR.
    task automatic add_frame(logic [7:0] seq, logic [7:0] cmd, logic [7:0] len,
                             frame_kind_t kind);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        sum = seq ^ cmd ^ len;
        add_byte(hdr_cfg);
        add_byte(seq);
        add_byte(cmd);
        add_byte(len);
        // An oversized length sends the parser back to the hunt right away.
        if (kind == FR_TOO_LONG)
            return;
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            sum ^= b;
            add_byte(b);
        end
        if (kind == FR_BAD_CHECK)
            add_byte(~sum ^ 8'($urandom_range(1, 255)));
        else
            add_byte(~sum);
        if (kind == FR_BAD_END)
            add_byte(end_cfg ^ 8'($urandom_range(1, 255)));
        else
            add_byte(end_cfg);
    endtask

    // One random chunk of traffic. Most chunks are well-formed frames; the
    // rest are broken frames and loose noise bytes.
    task automatic add_random_traffic();
        int         pick;
        int         top;
        int         n;
        logic [7:0] len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        top = (int'(max_cfg) < 12) ? int'(max_cfg) : 12;
        len = 8'($urandom_range(0, top));
        if (pick < 70)
        begin
            add_frame(8'($urandom), 8'($urandom), len, FR_GOOD);
        end
        else if (pick < 80)
        begin
            add_frame(8'($urandom), 8'($urandom), len, FR_BAD_CHECK);
        end
        else if (pick < 86)
        begin
            add_frame(8'($urandom), 8'($urandom), len, FR_BAD_END);
        end
        else if (pick < 92 && max_cfg != 8'hFF)
        begin
            add_frame(8'($urandom), 8'($urandom),
                      8'($urandom_range(int'(max_cfg) + 1, 255)), FR_TOO_LONG);
        end
        else
        begin
            // Noise mostly steers clear of the header value. Otherwise a
            // random length could swallow the frames that follow.
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                b = 8'($urandom);
                if (b == hdr_cfg && $urandom_range(0, 3) != 0)
                    b ^= 8'h01;
                add_byte(b);
            end
        end
    endtask

    // Waits until every queued byte has been taken and every predicted result
    // item has come back. Then it lets the block's input and result registers settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || rx_valid || deframed_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Writes one register and mirrors the value once the write is taken.
    task automatic cfg_write(logic [sfrx_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sfrx_pkg::CFG_HEADER_BYTE: hdr_cfg = data;
            sfrx_pkg::CFG_END_BYTE:    end_cfg = data;
            sfrx_pkg::CFG_MAX_LEN:     max_cfg = data;
            default:                   ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] hdr, logic [7:0] eb, logic [7:0] mx);
        wait_drained();
        cfg_write(sfrx_pkg::CFG_HEADER_BYTE, hdr);
        cfg_write(sfrx_pkg::CFG_END_BYTE, eb);
        cfg_write(sfrx_pkg::CFG_MAX_LEN, mx);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int         ph_i;
        int         goal;
        int         half;
        bit         paused;
        logic [7:0] hdr;
        logic [7:0] eb;
        logic [7:0] mx;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Hand-built part, with the reset configuration (header 0, end 0,
        // maximum length 255).
        // A line error while idle must leave rx_busy low. A plain byte in the
        // hunt sets it.
        add_raw(8'hFF, 1'b1);
        add_raw(8'h5A, 1'b0);
        // Zero-length frame with a good check byte.
        add_frame(8'hFF, 8'h00, 8'h00, FR_GOOD);
        // Two payload bytes, a line error in mid-frame that must be skipped,
        // and a check byte that does not match (the good one is 0x24).
        add_raw(8'h00, 1'b0);
        add_raw(8'h12, 1'b0);
        add_raw(8'h00, 1'b1);
        add_raw(8'h34, 1'b0);
        add_raw(8'h02, 1'b0);
        add_raw(8'hFF, 1'b0);
        add_raw(8'h00, 1'b0);
        add_raw(8'h25, 1'b0);
        add_raw(8'h00, 1'b0);
        // A wrong end byte drops the frame silently.
        add_frame(8'h01, 8'h02, 8'h01, FR_BAD_END);

        // Randomized phases, each with a setting of its own.
        for (ph_i = 0; ph_i < 5; ph_i++)
        begin
            case (ph_i)
                0:
                begin
                    hdr = 8'hFF;
                    eb = 8'hFF;
                    mx = 8'hFF;
                end
                1:
                begin
                    hdr = 8'h00;
                    eb = 8'h00;
                    mx = 8'h01;
                end
                2:
                begin
                    hdr = 8'($urandom);
                    eb = 8'($urandom);
                    mx = 8'($urandom_range(2, 12));
                end
                3:
                begin
                    hdr = 8'($urandom);
                    eb = 8'($urandom);
                    mx = 8'($urandom_range(1, 255));
                end
                default:
                begin
                    // Header and end share one value here.
                    hdr = 8'($urandom);
                    eb = hdr;
                    mx = 8'h05;
                end
            endcase
            set_config(hdr, eb, mx);
            line_err_pct = (ph_i == 3) ? 0 : 5;

            // Phase-specific openers: the longest payload the block allows,
            // and a length just past the limit.
            if (ph_i == 0)
                add_frame(8'($urandom), 8'($urandom), 8'hFF, FR_GOOD);
            if (ph_i == 1)
                add_frame(8'hA5, 8'h5A, 8'h02, FR_TOO_LONG);

            goal = fed_bytes + 24;
            half = fed_bytes + 12;
            paused = 1'b0;
            while (fed_bytes < goal)
            begin
                // Switch between random idling and back-to-back stretches now
                // and then.
                if ($urandom_range(0, 9) == 0)
                    sender_burst = ~sender_burst;
                if ($urandom_range(0, 9) == 0)
                    sink_burst = ~sink_burst;
                add_random_traffic();
                // Midway through one phase, stop sending until the block has
                // returned every result item.
                if (ph_i == 2 && !paused && fed_bytes >= half)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                while (byte_q.size() > 8)
                    @(negedge clk);
            end
        end

        // Wait until all bytes are taken, then give the last results a bound.
        while (byte_q.size() != 0 || rx_valid)
            @(negedge clk);
        goal = 0;
        while (deframed_q.size() != 0 && goal < 5000)
        begin
            @(negedge clk);
            goal++;
        end
        repeat (8) @(negedge clk);
        if (deframed_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      deframed_q.size()));

        if (n_mismatch == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

### serial_frame_receiver_xor_check.f
rtl/sfrx_pkg.sv
rtl/sfrx_cfg_regs.sv
rtl/sfrx_parser.sv
rtl/serial_frame_receiver_xor_check.sv
verif/testbench.sv
